FILE: rtl/core/swfr_pkg.sv
// Shared types and constants of the sliding-window sender core.
// No dependencies; imported by swfr_front, swfr_back and the top level.
package swfr_pkg;

    localparam int SEQ_W   = 32;
    localparam int REF_W   = 16;
    localparam int LIMIT_W = 4;
    localparam int DUP_W   = 4;

    localparam int WINDOW_SIZE_DEFAULT = 8;
    localparam int CMD_FIFO_DEPTH      = 2;

    localparam logic [LIMIT_W-1:0] DUP_LIMIT_RESET = 4'd4;
    localparam logic [SEQ_W-1:0]   SEQ_RESET       = 32'd1;
    localparam logic [SEQ_W-1:0]   SEQ_MAX         = 32'hFFFF_FFFF;

    // Stream word layouts
    localparam int S_TDATA_W = 48;  // payload_ref, ack_number
    localparam int S_TUSER_W = 3;   // mode, checksum_ok
    localparam int M_TDATA_W = 112; // tx_seq, tx_payload_ref, timer_stop_seq, timer_start_seq
    localparam int M_TUSER_W = 5;   // accepted, waiting, transmit, timer_stop, timer_start

    // Event kinds as they arrive on the input word
    localparam logic [1:0] MODE_SEND  = 2'd0;
    localparam logic [1:0] MODE_ACK   = 2'd1;
    localparam logic [1:0] MODE_TIMER = 2'd2;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_ACK,
        OP_TIMER,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [REF_W-1:0] payload_ref;
        logic [SEQ_W-1:0] ack_number;
    } cmd_t;

    typedef struct packed {
        logic             accepted;
        logic             waiting;
        logic             transmit;
        logic [SEQ_W-1:0] tx_seq;
        logic [REF_W-1:0] tx_payload_ref;
        logic             timer_stop;
        logic [SEQ_W-1:0] timer_stop_seq;
        logic             timer_start;
        logic [SEQ_W-1:0] timer_start_seq;
    } res_t;

endpackage

FILE: rtl/core/swfr_front.sv
// Front end: accepts input words, classifies each event and queues it.
// Depends on swfr_pkg for the command type and queue depth.
module swfr_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swfr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [swfr_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output swfr_pkg::cmd_t                 cmd
);
    import swfr_pkg::*;

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             queue_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             in_cmd;
    logic             push, pop;

    // Classify: a bad-checksum ACK or an unknown mode becomes a no-op
    always_comb begin
        in_cmd.payload_ref = s_tdata[REF_W-1:0];
        in_cmd.ack_number  = s_tdata[REF_W +: SEQ_W];
        case (s_tuser[1:0])
            MODE_SEND:  in_cmd.op = OP_SEND;
            MODE_ACK:   in_cmd.op = s_tuser[2] ? OP_ACK : OP_NONE;
            MODE_TIMER: in_cmd.op = OP_TIMER;
            default:    in_cmd.op = OP_NONE;
        endcase
    end

    assign s_tready  = (count_reg != CNT_W'(CMD_FIFO_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: rtl/core/swfr_back.sv
// Back end: window state, payload ring memory and registered result word.
// Depends on swfr_pkg for command/result types and reset constants.
module swfr_back #(
    parameter int WINDOW_SIZE = swfr_pkg::WINDOW_SIZE_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [swfr_pkg::LIMIT_W-1:0] cfg_wdata,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  swfr_pkg::cmd_t               cmd,
    output logic                         res_valid,
    input  logic                         res_ready,
    output swfr_pkg::res_t               res
);
    import swfr_pkg::*;

    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [REF_W-1:0]   payload_mem [WINDOW_SIZE];
    logic [REF_W-1:0]   head_ref_reg;

    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic [CNT_W-1:0]   in_flight_reg, in_flight_next;
    logic [DUP_W-1:0]   dup_count_reg, dup_count_next;
    logic               full_reg, full_next;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic [LIMIT_W-1:0] dup_limit_reg;
    logic               out_valid_reg;
    res_t               out_reg, out_next;

    logic               exec;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_idx, slide_idx;
    logic [SUM_W-1:0]   wr_sum, slide_sum;
    logic [CNT_W-1:0]   slide_num;
    logic [DUP_W-1:0]   dup_inc;
    logic               ack_in_range;

    assign cmd_ready = !out_valid_reg || res_ready;
    assign exec      = cmd_valid && cmd_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Ring positions: tail for a new packet, new head after a slide
    always_comb begin
        wr_sum    = SUM_W'(oldest_reg) + SUM_W'(in_flight_reg);
        wr_idx    = (wr_sum >= SUM_W'(WINDOW_SIZE)) ?
                    IDX_W'(wr_sum - SUM_W'(WINDOW_SIZE)) : IDX_W'(wr_sum);
        slide_num = CNT_W'(cmd.ack_number - base_reg);
        slide_sum = SUM_W'(oldest_reg) + SUM_W'(slide_num);
        slide_idx = (slide_sum >= SUM_W'(WINDOW_SIZE)) ?
                    IDX_W'(slide_sum - SUM_W'(WINDOW_SIZE)) : IDX_W'(slide_sum);
        dup_inc   = dup_count_reg + 1'b1;
        ack_in_range = (in_flight_reg != '0) && (cmd.ack_number >= base_reg)
                       && (cmd.ack_number <= next_seq_reg);
    end

    always_comb begin
        base_next      = base_reg;
        next_seq_next  = next_seq_reg;
        in_flight_next = in_flight_reg;
        dup_count_next = dup_count_reg;
        full_next      = full_reg;
        oldest_next    = oldest_reg;
        mem_we         = 1'b0;
        out_next       = '0;
        case (cmd.op)
            OP_SEND: begin
                if (next_seq_reg != SEQ_MAX && in_flight_reg != CNT_W'(WINDOW_SIZE)) begin
                    mem_we                  = 1'b1;
                    full_next               = 1'b0;
                    out_next.accepted       = 1'b1;
                    out_next.transmit       = 1'b1;
                    out_next.tx_seq         = next_seq_reg;
                    out_next.tx_payload_ref = cmd.payload_ref;
                    if (in_flight_reg == '0) begin
                        out_next.timer_start     = 1'b1;
                        out_next.timer_start_seq = next_seq_reg;
                    end
                    in_flight_next = in_flight_reg + 1'b1;
                    next_seq_next  = next_seq_reg + 1'b1;
                end else begin
                    full_next = 1'b1;
                end
            end
            OP_ACK: begin
                if (ack_in_range) begin
                    if (cmd.ack_number == base_reg) begin
                        // Duplicate of the oldest packet
                        dup_count_next = dup_inc;
                        if (dup_inc == dup_limit_reg) begin
                            dup_count_next           = '0;
                            out_next.transmit        = 1'b1;
                            out_next.tx_seq          = base_reg;
                            out_next.tx_payload_ref  = head_ref_reg;
                            out_next.timer_stop      = 1'b1;
                            out_next.timer_stop_seq  = base_reg;
                            out_next.timer_start     = 1'b1;
                            out_next.timer_start_seq = base_reg;
                        end else if (dup_inc == DUP_W'(1)) begin
                            out_next.timer_stop      = 1'b1;
                            out_next.timer_stop_seq  = base_reg;
                            out_next.timer_start     = 1'b1;
                            out_next.timer_start_seq = base_reg;
                        end
                    end else begin
                        // New cumulative ack: slide
                        dup_count_next          = DUP_W'(1);
                        base_next               = cmd.ack_number;
                        oldest_next             = slide_idx;
                        in_flight_next          = in_flight_reg - slide_num;
                        out_next.timer_stop     = 1'b1;
                        out_next.timer_stop_seq = base_reg;
                        if (cmd.ack_number != next_seq_reg) begin
                            out_next.timer_start     = 1'b1;
                            out_next.timer_start_seq = cmd.ack_number;
                        end
                    end
                end
            end
            OP_TIMER: begin
                if (in_flight_reg != '0) begin
                    out_next.transmit        = 1'b1;
                    out_next.tx_seq          = base_reg;
                    out_next.tx_payload_ref  = head_ref_reg;
                    out_next.timer_stop      = 1'b1;
                    out_next.timer_stop_seq  = base_reg;
                    out_next.timer_start     = 1'b1;
                    out_next.timer_start_seq = base_reg;
                end
            end
            default: begin
            end
        endcase
        out_next.waiting = full_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= SEQ_RESET;
            next_seq_reg  <= SEQ_RESET;
            in_flight_reg <= '0;
            dup_count_reg <= '0;
            full_reg      <= 1'b0;
            oldest_reg    <= '0;
            dup_limit_reg <= DUP_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                dup_limit_reg <= cfg_wdata;
            end
            if (exec) begin
                base_reg      <= base_next;
                next_seq_reg  <= next_seq_next;
                in_flight_reg <= in_flight_next;
                dup_count_reg <= dup_count_next;
                full_reg      <= full_next;
                oldest_reg    <= oldest_next;
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            out_reg <= out_next;
        end
    end

    // Payload ring; head_ref_reg tracks the oldest slot, with write bypass
    always_ff @(posedge aclk) begin
        if (exec) begin
            if (mem_we) begin
                payload_mem[wr_idx] <= cmd.payload_ref;
            end
            if (mem_we && wr_idx == oldest_next) begin
                head_ref_reg <= cmd.payload_ref;
            end else begin
                head_ref_reg <= payload_mem[oldest_next];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_in_flight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight_reg <= CNT_W'(WINDOW_SIZE))
        else $error("in-flight count exceeds window size");

    a_window_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_seq_reg - base_reg) == SEQ_W'(in_flight_reg))
        else $error("window span disagrees with in-flight count");

    a_base_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg != '0)
        else $error("window base dropped to zero");

    a_accept_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.accepted |-> out_reg.transmit && !out_reg.waiting)
        else $error("accepted send without transmit or with waiting set");
`endif

endmodule

FILE: rtl/core/sliding_window_sender_fast_retransmit_core.sv
// Top level of the sliding-window sender with fast retransmit.
// Depends on swfr_pkg, swfr_front and swfr_back.
//
//  channel | direction | word contents (lowest bit first)
//  --------+-----------+--------------------------------------------------
//  s_      | in        | tdata: payload_ref[15:0], ack_number[47:16]
//          |           | tuser: mode[1:0], checksum_ok[2]
//  m_      | out       | tdata: tx_seq[31:0], tx_payload_ref[47:32],
//          |           |        timer_stop_seq[79:48], timer_start_seq[111:80]
//          |           | tuser: accepted[0], waiting[1], transmit[2],
//          |           |        timer_stop[3], timer_start[4]
//  cfg_    | in        | cfg_we, cfg_wdata = dup_ack_limit[3:0]
//
// One event per cycle while m_ takes results; a taken input word is written into
// the command queue register, then into the result register, where it is valid
// on m_ and held until m_tready.
// The window state update and the payload ring write happen in the single
// cycle the back end takes an event; head payload is kept in a register.
// Reset (aresetn low, synchronous) empties the queue, base and next
// sequence to 1, limit to 4. Ring contents need no clearing.
// A stalled m_ side holds the result register; the two-entry command queue
// keeps s_tready high until it fills.
module sliding_window_sender_fast_retransmit_core #(
    parameter int WINDOW_SIZE = swfr_pkg::WINDOW_SIZE_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: dup_ack_limit
    input  logic                           cfg_we,
    input  logic [swfr_pkg::LIMIT_W-1:0]   cfg_wdata,
    // input events
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swfr_pkg::S_TDATA_W-1:0] s_tdata,  // payload_ref, ack_number
    input  logic [swfr_pkg::S_TUSER_W-1:0] s_tuser,  // mode, checksum_ok
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swfr_pkg::M_TDATA_W-1:0] m_tdata,  // tx_seq, tx_payload_ref,
                                                     // timer_stop_seq, timer_start_seq
    output logic [swfr_pkg::M_TUSER_W-1:0] m_tuser   // accepted, waiting, transmit,
                                                     // timer_stop, timer_start
);
    import swfr_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;
    res_t res;

    // Classify and queue incoming words
    swfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Apply events to the window and register one result each
    swfr_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result word: sequence numbers and handle in tdata, flags in tuser
    assign m_tdata = {res.timer_start_seq, res.timer_stop_seq,
                      res.tx_payload_ref, res.tx_seq};
    assign m_tuser = {res.timer_start, res.timer_stop, res.transmit,
                      res.waiting, res.accepted};

endmodule

FILE: tb/tb.sv
// Self-checking bench for the sliding-window sender core: directed words, then random
// send/ACK/timer traffic checked word by word against a window predictor.
// Depends on swfr_pkg and sliding_window_sender_fast_retransmit_core.
module tb;
    import swfr_pkg::*;

    localparam int WIN            = WINDOW_SIZE_DEFAULT;
    localparam int DIR_N          = 24;
    localparam int HOLD_CYCLES    = 48;
    localparam int LATENCY_SLACK  = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        op_t              op;
        logic [REF_W-1:0] pref;
        logic [SEQ_W-1:0] ack;
        logic             ck;
        logic             typed;
        res_t             want;
    } dir_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    sliding_window_sender_fast_retransmit_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // payload_ref, ack_number
        .s_tuser   (s_tuser),   // mode, checksum_ok
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // tx_seq, tx_payload_ref, timer_stop_seq, timer_start_seq
        .m_tuser   (m_tuser)    // accepted, waiting, transmit, timer_stop, timer_start
    );

    // Window predictor state
    logic [SEQ_W-1:0]   win_base;
    logic [SEQ_W-1:0]   nxt_seq;
    int unsigned        inflight;
    logic [DUP_W-1:0]   dups;
    logic               full;
    logic [SEQ_W-1:0]   ring_seq [WIN];
    logic [REF_W-1:0]   ring_ref [WIN];
    int unsigned        head;
    logic [LIMIT_W-1:0] dup_limit;

    res_t expected_results [$];

    int  errors        = 0;
    int  n_items       = 0;
    int  n_results     = 0;
    int  n_refused     = 0;
    int  n_fast_retx   = 0;
    int  n_timer_resend = 0;
    int  n_slides      = 0;
    bit  gaps_on       = 1'b1;
    int  burst_left    = 0;
    bit  hold_request  = 1'b0;

    dir_row_t dir_rows [DIR_N];

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Build an expected word; a sequence of zero means that flag is low,
    // since sequence numbers start at one.
    function automatic res_t want_of(logic acc, logic wt, logic [SEQ_W-1:0] txs,
                                     logic [REF_W-1:0] txr, logic [SEQ_W-1:0] sps,
                                     logic [SEQ_W-1:0] sts);
        res_t r;
        r.accepted        = acc;
        r.waiting         = wt;
        r.transmit        = (txs != 0);
        r.tx_seq          = txs;
        r.tx_payload_ref  = txr;
        r.timer_stop      = (sps != 0);
        r.timer_stop_seq  = sps;
        r.timer_start     = (sts != 0);
        r.timer_start_seq = sts;
        return r;
    endfunction

    // Advance the predicted window by one event and return the word it yields.
    task automatic window_step(input op_t op, input logic [REF_W-1:0] pref,
                               input logic [SEQ_W-1:0] ack, input logic ck,
                               output res_t r);
        int unsigned      idx;
        logic [SEQ_W-1:0] old_seq;
        logic [SEQ_W-1:0] num;
        logic             slide;
        r     = '0;
        num   = '0;
        slide = 1'b0;
        case (op)
            OP_SEND: begin
                if (nxt_seq != SEQ_MAX && 33'(nxt_seq) < 33'(win_base) + 33'(WIN) &&
                    inflight < WIN) begin
                    idx           = (head + inflight) % WIN;
                    ring_seq[idx] = nxt_seq;
                    ring_ref[idx] = pref;
                    full          = 1'b0;
                    r.accepted    = 1'b1;
                    // first packet into an empty window arms the timer
                    if (win_base == nxt_seq) begin
                        r.timer_start     = 1'b1;
                        r.timer_start_seq = nxt_seq;
                    end
                    r.transmit       = 1'b1;
                    r.tx_seq         = nxt_seq;
                    r.tx_payload_ref = pref;
                    inflight++;
                    nxt_seq++;
                end else begin
                    full = 1'b1;
                    n_refused++;
                end
            end
            OP_ACK: begin
                if (inflight > 0 && ck && ack >= win_base && ack <= nxt_seq) begin
                    old_seq = ring_seq[head];
                    if (ack == old_seq) begin
                        dups = dups + 1'b1;
                        if (dups == dup_limit) begin
                            // fast retransmit of the oldest packet
                            r.timer_stop      = 1'b1;
                            r.timer_stop_seq  = old_seq;
                            r.transmit        = 1'b1;
                            r.tx_seq          = old_seq;
                            r.tx_payload_ref  = ring_ref[head];
                            r.timer_start     = 1'b1;
                            r.timer_start_seq = old_seq;
                            dups              = '0;
                            n_fast_retx++;
                        end else if (dups == 1) begin
                            slide = 1'b1;
                        end
                    end else begin
                        dups  = DUP_W'(1);
                        num   = ack - win_base;
                        slide = 1'b1;
                    end
                    if (slide) begin
                        if (num > inflight) num = inflight;
                        win_base         = ack;
                        r.timer_stop     = 1'b1;
                        r.timer_stop_seq = old_seq;
                        if (win_base != nxt_seq) begin
                            r.timer_start     = 1'b1;
                            r.timer_start_seq = ring_seq[(head + num) % WIN];
                        end
                        head     = (head + num) % WIN;
                        inflight = inflight - num;
                        n_slides++;
                    end
                end
            end
            OP_TIMER: begin
                if (inflight > 0) begin
                    r.timer_stop      = 1'b1;
                    r.timer_stop_seq  = ring_seq[head];
                    r.timer_start     = 1'b1;
                    r.timer_start_seq = ring_seq[head];
                    r.transmit        = 1'b1;
                    r.tx_seq          = ring_seq[head];
                    r.tx_payload_ref  = ring_ref[head];
                    n_timer_resend++;
                end
            end
            default: ;
        endcase
        r.waiting = full;
    endtask

    // Offer one event word; on acceptance predict its result word, or take
    // the typed-in one for the plain directed rows.
    task automatic issue_word(input op_t op, input logic [REF_W-1:0] pref,
                              input logic [SEQ_W-1:0] ack, input logic ck,
                              input logic typed = 1'b0, input res_t want = '0);
        int   gap;
        res_t r;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ack, pref};
        s_tuser  <= {ck, 2'(op)};
        do @(posedge aclk); while (!s_tready);
        window_step(op, pref, ack, ck, r);
        expected_results.push_back(typed ? want : r);
        n_items++;
    endtask

    // Drop valid and hold until every expected word is back, plus slack
    // for anything still inside the pipe.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (LATENCY_SLACK) @(posedge aclk);
    endtask

    task automatic write_dup_limit(input logic [LIMIT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        dup_limit  = v;
    endtask

    // One stretch of random traffic shaped like real sender activity.
    task automatic random_episode();
        int k;
        int i;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // fill burst; long ones run into a full window
                k = $urandom_range(1, 10);
                for (i = 0; i < k; i++)
                    issue_word(OP_SEND, 16'($urandom), 32'($urandom), 1'($urandom));
            end
            4, 5: begin
                // duplicate storm on the oldest packet
                k = int'(dup_limit) + $urandom_range(0, 2);
                for (i = 0; i < k; i++)
                    issue_word(OP_ACK, 16'($urandom), win_base,
                               ($urandom_range(0, 15) != 0));
            end
            6, 7: begin
                // cumulative acks inside the window
                k = $urandom_range(1, 3);
                for (i = 0; i < k; i++)
                    issue_word(OP_ACK, 16'($urandom), win_base + $urandom_range(0, inflight),
                               ($urandom_range(0, 9) != 0));
            end
            8: begin
                k = $urandom_range(1, 2);
                for (i = 0; i < k; i++)
                    issue_word(OP_TIMER, 16'($urandom), 32'($urandom), 1'($urandom));
            end
            default: begin
                // noise: any kind, any ack, any checksum
                issue_word(op_t'($urandom_range(0, 3)), 16'($urandom), 32'($urandom),
                           1'($urandom));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Result checker: compare each accepted word with the oldest expectation.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $error("result word with no expectation pending");
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("accepted",        want.accepted,        m_tuser[0]);
                check_field("waiting",         want.waiting,         m_tuser[1]);
                check_field("transmit",        want.transmit,        m_tuser[2]);
                check_field("timer_stop",      want.timer_stop,      m_tuser[3]);
                check_field("timer_start",     want.timer_start,     m_tuser[4]);
                check_field("tx_seq",          want.tx_seq,          m_tdata[31:0]);
                check_field("tx_payload_ref",  want.tx_payload_ref,  m_tdata[47:32]);
                check_field("timer_stop_seq",  want.timer_stop_seq,  m_tdata[79:48]);
                check_field("timer_start_seq", want.timer_start_seq, m_tdata[111:80]);
            end
        end
    end

    // Receiver: rotate among always-ready, coin-flip and periodic stall
    // patterns; a hold request forces a long stretch of back-pressure.
    initial begin
        int style_left;
        int style;
        int hold_left;
        int tick;
        style_left = 0;
        style      = 0;
        hold_left  = 0;
        tick       = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 2);
                style_left = $urandom_range(20, 80);
            end
            style_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom);
                    default: m_tready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int i;
        int target;
        win_base  = SEQ_RESET;
        nxt_seq   = SEQ_RESET;
        inflight  = 0;
        dups      = '0;
        full      = 1'b0;
        head      = 0;
        dup_limit = DUP_LIMIT_RESET;
        for (i = 0; i < WIN; i++) begin
            ring_seq[i] = '0;
            ring_ref[i] = '0;
        end

        // Directed rows: empty-window events, first sends, a full window,
        // rejected acks, duplicates up to fast retransmit, timeout, slides.
        dir_rows = '{
            '{OP_TIMER, 16'h0000, 32'd0,          1'b1, 1'b1, want_of(0, 0, 0, 0, 0, 0)},
            '{OP_ACK,   16'h0000, 32'd1,          1'b1, 1'b1, want_of(0, 0, 0, 0, 0, 0)},
            '{OP_NONE,  16'hFFFF, 32'hFFFF_FFFF,  1'b1, 1'b1, want_of(0, 0, 0, 0, 0, 0)},
            '{OP_SEND,  16'h0000, 32'd0,          1'b0, 1'b1,
              want_of(1, 0, 32'd1, 16'h0000, 0, 32'd1)},
            '{OP_SEND,  16'hFFFF, 32'hFFFF_FFFF,  1'b1, 1'b1,
              want_of(1, 0, 32'd2, 16'hFFFF, 0, 0)},
            '{OP_SEND,  16'h5A5A, 32'd0,          1'b0, 1'b0, '0},
            '{OP_SEND,  16'hA5A5, 32'd0,          1'b0, 1'b0, '0},
            '{OP_SEND,  16'h0001, 32'd0,          1'b0, 1'b0, '0},
            '{OP_SEND,  16'h8000, 32'd0,          1'b0, 1'b0, '0},
            '{OP_SEND,  16'h7FFF, 32'd0,          1'b0, 1'b0, '0},
            '{OP_SEND,  16'h00FF, 32'd0,          1'b0, 1'b0, '0},
            // window full: refused, waiting raised
            '{OP_SEND,  16'h1234, 32'd0,          1'b0, 1'b1, want_of(0, 1, 0, 0, 0, 0)},
            // ack below base, ack beyond next sequence, bad checksum
            '{OP_ACK,   16'h0000, 32'd0,          1'b1, 1'b1, want_of(0, 1, 0, 0, 0, 0)},
            '{OP_ACK,   16'h0000, 32'hFFFF_FFFF,  1'b1, 1'b1, want_of(0, 1, 0, 0, 0, 0)},
            '{OP_ACK,   16'h0000, 32'd3,          1'b0, 1'b1, want_of(0, 1, 0, 0, 0, 0)},
            // duplicates of the oldest packet up to the reset limit
            '{OP_ACK,   16'h0000, 32'd1,          1'b1, 1'b0, '0},
            '{OP_ACK,   16'h0000, 32'd1,          1'b1, 1'b0, '0},
            '{OP_ACK,   16'h0000, 32'd1,          1'b1, 1'b0, '0},
            '{OP_ACK,   16'h0000, 32'd1,          1'b1, 1'b0, '0},
            '{OP_TIMER, 16'h0000, 32'd0,          1'b0, 1'b0, '0},
            '{OP_ACK,   16'h0000, 32'd4,          1'b1, 1'b0, '0},
            '{OP_SEND,  16'hC3C3, 32'd0,          1'b0, 1'b0, '0},
            // acknowledge everything: window drains
            '{OP_ACK,   16'h0000, 32'd10,         1'b1, 1'b0, '0},
            '{OP_TIMER, 16'hFFFF, 32'hFFFF_FFFF,  1'b1, 1'b1, want_of(0, 0, 0, 0, 0, 0)}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_N; i++)
            issue_word(dir_rows[i].op, dir_rows[i].pref, dir_rows[i].ack, dir_rows[i].ck,
                       dir_rows[i].typed, dir_rows[i].want);

        // Phase 1: smallest limit, sender never idles
        wait_for_results();
        write_dup_limit(4'd2);
        gaps_on = 1'b0;
        target  = n_items + 90;
        while (n_items < target) random_episode();

        // Phase 2: largest limit; start with a long receiver hold while
        // the sender keeps pushing, so the input side backs up
        wait_for_results();
        write_dup_limit(4'd15);
        hold_request = 1'b1;
        for (i = 0; i < 16; i++) random_episode();
        gaps_on = 1'b1;
        target  = n_items + 80;
        while (n_items < target) random_episode();

        // Phase 3: mid-range limit, with a full pause halfway through
        wait_for_results();
        write_dup_limit(4'd9);
        target = n_items + 45;
        while (n_items < target) random_episode();
        wait_for_results();
        target = n_items + 45;
        while (n_items < target) random_episode();

        // Phase 4: another small limit
        wait_for_results();
        write_dup_limit(4'd3);
        target = n_items + 70;
        while (n_items < target) random_episode();

        wait_for_results();

        $display("Covered %0d event words and %0d result words over limits 4, 2, 15, 9, 3.",
                 n_items, n_results);
        $display("Refused sends %0d, fast retransmits %0d, timer resends %0d, slides %0d.",
                 n_refused, n_fast_retx, n_timer_resend, n_slides);
        if (errors == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
